[rtl/core/msbb_pkg.sv]
// ----------------------------------------------------------------------------
// msbb_pkg
// Shared types and constants of the MSB-first bit buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package msbb_pkg;

  localparam int STORE_BYTES = 256;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int CNT_W       = 12;
  localparam int NB_W        = CNT_W - 2;

  localparam logic [CNT_W-1:0] CAP_BITS = CNT_W'(8 * STORE_BYTES);

  localparam logic [1:0] OP_BIT  = 2'd0;
  localparam logic [1:0] OP_BYTE = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_BYTE_HI,
    S_RD1,
    S_RD2
  } state_t;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_ERR,
    ACT_BIT,
    ACT_BYTE_AL,
    ACT_BYTE_LO,
    ACT_BYTE_HI,
    ACT_RD_ISSUE,
    ACT_RD_ONE,
    ACT_RD_NEXT,
    ACT_RD_TWO
  } act_t;

  typedef struct packed {
    act_t act;
  } ctrl_cmd_t;

  typedef struct packed {
    logic full_bit;
    logic full_byte;
    logic range;
    logic aligned;
    logic need_next;
  } dp_flags_t;

endpackage

`default_nettype wire

[rtl/core/msbb_ram.sv]
// ----------------------------------------------------------------------------
// msbb_ram
// Generic single-port RAM, one access per cycle, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module msbb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

[rtl/core/msbb_ctrl.sv]
// ----------------------------------------------------------------------------
// msbb_ctrl
// Sequencer: decodes each word and steps the datapath through its accesses.
// ----------------------------------------------------------------------------
`default_nettype none

module msbb_ctrl
  import msbb_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  input  wire logic [1:0] operation,
  input  wire dp_flags_t flags,
  output ctrl_cmd_t      cmd,
  output logic           busy
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.act    = ACT_NONE;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (operation)
            OP_BIT: begin
              cmd.act = flags.full_bit ? ACT_ERR : ACT_BIT;
            end
            OP_BYTE: begin
              if (flags.full_byte) begin
                cmd.act = ACT_ERR;
              end else if (flags.aligned) begin
                cmd.act = ACT_BYTE_AL;
              end else begin
                cmd.act    = ACT_BYTE_LO;
                state_next = S_BYTE_HI;
              end
            end
            OP_READ: begin
              if (flags.range) begin
                cmd.act = ACT_ERR;
              end else begin
                cmd.act    = ACT_RD_ISSUE;
                state_next = S_RD1;
              end
            end
            default: cmd.act = ACT_ERR;
          endcase
        end
      end
      S_BYTE_HI: begin
        cmd.act    = ACT_BYTE_HI;
        state_next = S_IDLE;
      end
      S_RD1: begin
        if (flags.need_next) begin
          cmd.act    = ACT_RD_NEXT;
          state_next = S_RD2;
        end else begin
          cmd.act    = ACT_RD_ONE;
          state_next = S_IDLE;
        end
      end
      S_RD2: begin
        cmd.act    = ACT_RD_TWO;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

`default_nettype wire

[rtl/core/msbb_dp.sv]
// ----------------------------------------------------------------------------
// msbb_dp
// Datapath: byte store, bit count, tail byte shadow and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module msbb_dp
  import msbb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire ctrl_cmd_t   cmd,
  input  wire logic [1:0]  operation,
  input  wire logic        bit_value,
  input  wire logic [7:0]  data_byte,
  input  wire logic [7:0]  read_index,
  input  wire logic [2:0]  bit_offset,
  output dp_flags_t        flags,
  output logic             done,
  output logic [7:0]       read_data,
  output logic [CNT_W-1:0] length_bits,
  output logic [1:0]       status
);

  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [7:0]        tail;      // copy of the partly filled byte, zeros past length
  logic [7:0]        tail_next;
  logic [7:0]        byte_q;
  logic [7:0]        idx_q;
  logic [2:0]        off_q;
  logic [7:0]        b0;

  logic [NB_W-1:0]   nbytes;
  logic [2:0]        used;
  logic [ADDR_W-1:0] cur_idx;
  logic [1:0]        st_live;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_addr;
  logic [7:0]        mem_wdata;
  logic [7:0]        mem_q;

  logic [15:0]       hi_word;
  logic [15:0]       rd_one;
  logic [15:0]       rd_two;
  logic [7:0]        bit_mask;
  logic              fin;
  logic [7:0]        data_res;

  assign nbytes  = NB_W'((13'(count) + 13'd7) >> 3);
  assign used    = count[2:0];
  assign cur_idx = count[ADDR_W+2:3];

  assign flags.full_bit  = (count >= CAP_BITS);
  assign flags.full_byte = (count > (CAP_BITS - CNT_W'(8)));
  assign flags.range     = (NB_W'(read_index) >= nbytes);
  assign flags.aligned   = (used == 3'd0);
  assign flags.need_next = (off_q != 3'd0) && ((NB_W'(idx_q) + NB_W'(1)) < nbytes);

  always_comb begin
    unique case (operation)
      OP_BIT:  st_live = flags.full_bit ? ST_FULL : ST_OK;
      OP_BYTE: st_live = flags.full_byte ? ST_FULL : ST_OK;
      OP_READ: st_live = flags.range ? ST_RANGE : ST_OK;
      default: st_live = ST_OK;
    endcase
  end

  assign bit_mask = bit_value ? (8'h80 >> used) : 8'h00;
  assign hi_word  = {byte_q, 8'h00} >> used;
  assign rd_one   = {mem_q, 8'h00} << off_q;
  assign rd_two   = {b0, mem_q} << off_q;

  always_comb begin
    mem_we     = 1'b0;
    mem_addr   = cur_idx;
    mem_wdata  = tail | bit_mask;
    count_next = count;
    tail_next  = tail;
    fin        = 1'b0;
    data_res   = 8'h00;
    unique case (cmd.act)
      ACT_ERR: begin
        fin = 1'b1;
      end
      ACT_BIT: begin
        mem_we     = 1'b1;
        count_next = count + CNT_W'(1);
        tail_next  = (used == 3'd7) ? 8'h00 : (tail | bit_mask);
        fin        = 1'b1;
      end
      ACT_BYTE_AL: begin
        mem_we     = 1'b1;
        mem_wdata  = data_byte;
        count_next = count + CNT_W'(8);
        tail_next  = 8'h00;
        fin        = 1'b1;
      end
      ACT_BYTE_LO: begin
        mem_we    = 1'b1;
        mem_wdata = tail | (data_byte >> used);
      end
      ACT_BYTE_HI: begin
        mem_we     = 1'b1;
        mem_addr   = cur_idx + ADDR_W'(1);
        mem_wdata  = hi_word[7:0];
        count_next = count + CNT_W'(8);
        tail_next  = hi_word[7:0];
        fin        = 1'b1;
      end
      ACT_RD_ISSUE: begin
        mem_addr = ADDR_W'(read_index);
      end
      ACT_RD_ONE: begin
        fin      = 1'b1;
        data_res = rd_one[15:8];
      end
      ACT_RD_NEXT: begin
        mem_addr = ADDR_W'(idx_q) + ADDR_W'(1);
      end
      ACT_RD_TWO: begin
        fin      = 1'b1;
        data_res = rd_two[15:8];
      end
      default: ;
    endcase
  end

  msbb_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      tail  <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      tail  <= tail_next;
      done  <= fin;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.act == ACT_BYTE_LO || cmd.act == ACT_RD_ISSUE) begin
      byte_q <= data_byte;
      idx_q  <= read_index;
      off_q  <= bit_offset;
    end
    if (cmd.act == ACT_RD_NEXT) begin
      b0 <= mem_q;
    end
    if (fin) begin
      read_data   <= data_res;
      length_bits <= count_next;
      status      <= (cmd.act == ACT_ERR) ? st_live : ST_OK;
    end
  end

endmodule

`default_nettype wire

[rtl/core/msb_first_bit_buffer.sv]
// ----------------------------------------------------------------------------
// msb_first_bit_buffer
// Byte store filled msb first: bit append, unaligned byte append and
// unaligned byte read, with full and out-of-range status.
// ----------------------------------------------------------------------------
//
//  channel   handshake          payload
//  -------   ----------------   ---------------------------------------------
//  command   start / busy       operation, bit_value, data_byte, read_index,
//                               bit_offset
//  result    done (one cycle)   read_data, length_bits, status
//
//  Bit append, aligned byte append and rejected words finish when taken.
//  Unaligned byte append writes the low byte, then the high byte; a read
//  reads its byte, then the next if needed, as the single-port store demands.
//  done pulses the cycle after the last step; busy may already be low then.
//  Reset clears the bit count, tail and done; reads never pass the fill count,
//  so the store needs no clearing pass. Results cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module msb_first_bit_buffer
  import msbb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  operation,
  input  wire logic        bit_value,
  input  wire logic [7:0]  data_byte,
  input  wire logic [7:0]  read_index,
  input  wire logic [2:0]  bit_offset,
  output logic             done,
  output logic [7:0]       read_data,
  output logic [CNT_W-1:0] length_bits,
  output logic [1:0]       status
);

  ctrl_cmd_t cmd;
  dp_flags_t flags;

  msbb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .flags     (flags),
    .cmd       (cmd),
    .busy      (busy)
  );

  msbb_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .operation   (operation),
    .bit_value   (bit_value),
    .data_byte   (data_byte),
    .read_index  (read_index),
    .bit_offset  (bit_offset),
    .flags       (flags),
    .done        (done),
    .read_data   (read_data),
    .length_bits (length_bits),
    .status      (status)
  );

endmodule

`default_nettype wire
